>>> sv/trcr_pkg.sv
// ----------------------------------------------------------------------------
// trcr_pkg: shared types and constants of the triangle coverage rasterizer
// Operation codes, controller states, controller/datapath command and status
// structs, and the fixed arithmetic widths of the edge-function datapath.
// ----------------------------------------------------------------------------
package trcr_pkg;

	// default grid edge in pixels (range 2 to 1024)
	localparam int GRID_DEF = 256;

	// vertex coordinate width, 32768 = 1.0
	localparam int CW = 16;
	// multiplier operand A: difference of two coordinates
	localparam int MAW = CW + 1;
	// multiplier operand B: pixel center minus scaled vertex (max grid 1024)
	localparam int PXW = 27;
	localparam int MBW = PXW + 1;
	localparam int PW = MAW + MBW;
	// edge function accumulator
	localparam int EW = 48;
	// covered pixel count
	localparam int CNTW = 17;
	localparam logic [CNTW-1:0] COUNT_MAX = {CNTW{1'b1}};
	// bounding box product width: coordinate times grid
	localparam int BBW = 27;

	// half-float blue values
	localparam logic [15:0] HALF_ONE = 16'h3C00;
	localparam logic [15:0] HALF_HALF = 16'h3800;

	// number of multiplier issue steps in setup; a drain step follows them
	localparam int MUL_STEPS = 8;
	localparam int STEPW = 4;

	typedef enum logic [1:0] {
		OP_DRAW  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_BOOT,
		ST_IDLE,
		ST_SETUP,
		ST_WALK,
		ST_RD,
		ST_CLR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [2:0] mul_sel;
		logic       walk_en;
		logic       clr_en;
		logic       rd_en;
		logic       res_load;
	} ctl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic area_zero;
		logic box_ok;
		logic walk_last;
		logic clr_last;
	} ctl_sts_t;

endpackage

>>> sv/trcr_ram.sv
// ----------------------------------------------------------------------------
// trcr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on the array.
// ----------------------------------------------------------------------------
module trcr_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> sv/trcr_dp.sv
// ----------------------------------------------------------------------------
// trcr_dp: rasterizer datapath
// Holds the item, bounding box, shared setup multiplier, incremental edge
// functions, coverage bitmap RAM, clear sweep counter and result register.
// ----------------------------------------------------------------------------
module trcr_dp import trcr_pkg::*; #(
	parameter int GRID = GRID_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ctl_cmd_t        cmd,
	output ctl_sts_t        sts,
	input  logic [1:0]      operation,
	input  logic [CW-1:0]   vert0_x,
	input  logic [CW-1:0]   vert0_y,
	input  logic [CW-1:0]   vert1_x,
	input  logic [CW-1:0]   vert1_y,
	input  logic [CW-1:0]   vert2_x,
	input  logic [CW-1:0]   vert2_y,
	input  logic [7:0]      pixel_col,
	input  logic [7:0]      pixel_row,
	output logic            painted,
	output logic [15:0]     blue_half,
	output logic [CNTW-1:0] covered_count
);

	localparam int IW = $clog2(GRID);
	localparam int DEPTH = GRID * GRID;
	localparam int AW = $clog2(DEPTH);

	// coordinate difference, 17-bit signed
	function automatic logic signed [MAW-1:0] sdiff(input logic [CW-1:0] a,
		input logic [CW-1:0] b);
		return $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	// step of an edge function for one pixel: difference times 65536
	function automatic logic signed [EW-1:0] step16(input logic signed [MAW-1:0] d);
		return {{(EW-MAW-16){d[MAW-1]}}, d, 16'b0};
	endfunction

	// item registers
	op_t             op_q;
	logic [CW-1:0]   vx_q [3];
	logic [CW-1:0]   vy_q [3];
	logic [7:0]      rcol_q;
	logic [7:0]      rrow_q;
	logic [IW-1:0]   c0_q, c1_q, r0_q, r1_q;
	logic            box_ok_q;
	logic [IW-1:0]   col_q, row_q;
	logic [CNTW-1:0] count_q;
	logic [AW-1:0]   clr_cnt_q;

	// e_q[0] is the signed area, e_q[1..3] the edge functions at the current pixel
	logic signed [EW-1:0] e_q [4];
	logic signed [EW-1:0] erow_q [3];

	// multiplier pipeline
	logic signed [PW-1:0] prod_s1;
	logic [2:0]           sel_s1;
	logic                 acc_s1;

	// bounding box from the incoming vertices
	logic [CW-1:0]  mnx, mxx, mny, mxy;
	logic [BBW-1:0] c0_w, c1_w, r0_w, r1_w;

	always_comb begin
		mnx = vert0_x;
		mxx = vert0_x;
		mny = vert0_y;
		mxy = vert0_y;
		if (vert1_x < mnx) mnx = vert1_x;
		if (vert2_x < mnx) mnx = vert2_x;
		if (vert1_x > mxx) mxx = vert1_x;
		if (vert2_x > mxx) mxx = vert2_x;
		if (vert1_y < mny) mny = vert1_y;
		if (vert2_y < mny) mny = vert2_y;
		if (vert1_y > mxy) mxy = vert1_y;
		if (vert2_y > mxy) mxy = vert2_y;
		c0_w = (BBW'(mnx) * BBW'(GRID)) >> 15;
		c1_w = (BBW'(mxx) * BBW'(GRID)) >> 15;
		r0_w = (BBW'(mny) * BBW'(GRID)) >> 15;
		r1_w = (BBW'(mxy) * BBW'(GRID)) >> 15;
	end

	// item load
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(operation);
			vx_q[0]  <= vert0_x;
			vx_q[1]  <= vert1_x;
			vx_q[2]  <= vert2_x;
			vy_q[0]  <= vert0_y;
			vy_q[1]  <= vert1_y;
			vy_q[2]  <= vert2_y;
			rcol_q   <= pixel_col;
			rrow_q   <= pixel_row;
			box_ok_q <= (c0_w < BBW'(GRID)) && (r0_w < BBW'(GRID));
			c0_q     <= IW'(c0_w);
			r0_q     <= IW'(r0_w);
			c1_q     <= (c1_w >= BBW'(GRID)) ? IW'(GRID - 1) : IW'(c1_w);
			r1_q     <= (r1_w >= BBW'(GRID)) ? IW'(GRID - 1) : IW'(r1_w);
		end
	end

	// scaled pixel center of the box corner and scaled vertices
	logic [PXW-1:0] px0, py0;
	logic [PXW-1:0] sx [3];
	logic [PXW-1:0] sy [3];

	always_comb begin
		px0 = (PXW'(c0_q) << 16) | (PXW'(1) << 15);
		py0 = (PXW'(r0_q) << 16) | (PXW'(1) << 15);
		for (int k = 0; k < 3; k++) begin
			sx[k] = PXW'(vx_q[k]) * PXW'(2 * GRID);
			sy[k] = PXW'(vy_q[k]) * PXW'(2 * GRID);
		end
	end

	function automatic logic signed [MBW-1:0] cdiff(input logic [PXW-1:0] p,
		input logic [PXW-1:0] v);
		return $signed({1'b0, p}) - $signed({1'b0, v});
	endfunction

	function automatic logic signed [MBW-1:0] sext(input logic signed [MAW-1:0] d);
		return {{(MBW-MAW){d[MAW-1]}}, d};
	endfunction

	// multiplier operand select: area terms, then two terms per edge
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;

	always_comb begin
		case (cmd.mul_sel)
			3'd0: begin
				mul_a = sdiff(vy_q[0], vy_q[1]);
				mul_b = sext(sdiff(vx_q[2], vx_q[0]));
			end
			3'd1: begin
				mul_a = sdiff(vx_q[1], vx_q[0]);
				mul_b = sext(sdiff(vy_q[2], vy_q[0]));
			end
			3'd2: begin
				mul_a = sdiff(vy_q[1], vy_q[2]);
				mul_b = cdiff(px0, sx[1]);
			end
			3'd3: begin
				mul_a = sdiff(vx_q[2], vx_q[1]);
				mul_b = cdiff(py0, sy[1]);
			end
			3'd4: begin
				mul_a = sdiff(vy_q[2], vy_q[0]);
				mul_b = cdiff(px0, sx[2]);
			end
			3'd5: begin
				mul_a = sdiff(vx_q[0], vx_q[2]);
				mul_b = cdiff(py0, sy[2]);
			end
			3'd6: begin
				mul_a = sdiff(vy_q[0], vy_q[1]);
				mul_b = cdiff(px0, sx[0]);
			end
			3'd7: begin
				mul_a = sdiff(vx_q[1], vx_q[0]);
				mul_b = cdiff(py0, sy[0]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// setup multiplier stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
		end else begin
			acc_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= mul_a * mul_b;
			sel_s1  <= cmd.mul_sel;
		end
	end

	// per-edge column and row steps
	logic signed [MAW-1:0] da [3];
	logic signed [MAW-1:0] db [3];
	logic [2:0]            agree;
	logic                  in_tri;
	logic signed [EW-1:0]  prod_ext;
	logic [1:0]            acc_idx;
	logic                  row_end;

	always_comb begin
		da[0] = sdiff(vy_q[1], vy_q[2]);
		db[0] = sdiff(vx_q[2], vx_q[1]);
		da[1] = sdiff(vy_q[2], vy_q[0]);
		db[1] = sdiff(vx_q[0], vx_q[2]);
		da[2] = sdiff(vy_q[0], vy_q[1]);
		db[2] = sdiff(vx_q[1], vx_q[0]);
		for (int k = 0; k < 3; k++) begin
			agree[k] = (e_q[k+1] == '0) || (e_q[k+1][EW-1] == e_q[0][EW-1]);
		end
		in_tri   = &agree;
		prod_ext = {{(EW-PW){prod_s1[PW-1]}}, prod_s1};
		acc_idx  = sel_s1[2:1];
		row_end  = (col_q == c1_q);
	end

	// edge function accumulation in setup, incremental update in the walk
	always_ff @(posedge clk) begin
		if (acc_s1) begin
			if (!sel_s1[0]) begin
				e_q[acc_idx] <= prod_ext;
			end else begin
				e_q[acc_idx] <= e_q[acc_idx] + prod_ext;
			end
			if (acc_idx != 2'd0) begin
				if (!sel_s1[0]) begin
					erow_q[2'(acc_idx - 2'd1)] <= prod_ext;
				end else begin
					erow_q[2'(acc_idx - 2'd1)] <= e_q[acc_idx] + prod_ext;
				end
			end
		end else if (cmd.walk_en) begin
			for (int k = 0; k < 3; k++) begin
				if (row_end) begin
					e_q[k+1]  <= erow_q[k] + step16(db[k]);
					erow_q[k] <= erow_q[k] + step16(db[k]);
				end else begin
					e_q[k+1] <= e_q[k+1] + step16(da[k]);
				end
			end
		end
	end

	// walk position and covered count
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			col_q   <= IW'(c0_w);
			row_q   <= IW'(r0_w);
			count_q <= '0;
		end else if (cmd.walk_en) begin
			if (row_end) begin
				col_q <= c0_q;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
			if (in_tri && count_q != COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// clear sweep counter, returns to zero at the end of each pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= (clr_cnt_q == AW'(DEPTH - 1)) ? '0 : clr_cnt_q + 1'b1;
		end
	end

	// bitmap port control
	logic          rd_in;
	logic [AW-1:0] pix_addr, rd_addr;
	logic          wr_en, wr_data;
	logic [AW-1:0] wr_addr;
	logic          rd_bit;

	always_comb begin
		rd_in    = (int'(rcol_q) < GRID) && (int'(rrow_q) < GRID);
		pix_addr = AW'(row_q) * AW'(GRID) + AW'(col_q);
		rd_addr  = AW'(rrow_q) * AW'(GRID) + AW'(rcol_q);
		if (cmd.clr_en) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = 1'b0;
		end else begin
			wr_en   = cmd.walk_en && in_tri;
			wr_addr = pix_addr;
			wr_data = 1'b1;
		end
	end

	trcr_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_bitmap (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_bit)
	);

	// result register
	logic pnt;

	always_comb begin
		pnt = (op_q == OP_READ) && rd_in && rd_bit;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			painted       <= pnt;
			blue_half     <= (op_q != OP_READ) ? 16'h0 : (pnt ? HALF_ONE : HALF_HALF);
			covered_count <= (op_q == OP_DRAW) ? count_q : '0;
		end
	end

	// status to the controller
	always_comb begin
		sts.op        = op_q;
		sts.area_zero = (e_q[0] == '0);
		sts.box_ok    = box_ok_q;
		sts.walk_last = row_end && (row_q == r1_q);
		sts.clr_last  = (clr_cnt_q == AW'(DEPTH - 1));
	end

endmodule

>>> sv/trcr_ctrl.sv
// ----------------------------------------------------------------------------
// trcr_ctrl: rasterizer controller
// Sequences the boot clear, setup multiplies, pixel walk, bitmap read and
// bitmap clear, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module trcr_ctrl import trcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] operation,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output ctl_cmd_t   cmd,
	input  ctl_sts_t   sts
);

	state_t            state_q, state_nx;
	logic [STEPW-1:0]  step_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_BOOT: begin
				if (sts.clr_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(operation))
						OP_DRAW:  state_nx = ST_SETUP;
						OP_READ:  state_nx = ST_RD;
						OP_CLEAR: state_nx = ST_CLR;
						default:  state_nx = ST_DONE;
					endcase
				end
			end
			ST_SETUP: begin
				if (step_q == STEPW'(MUL_STEPS)) begin
					state_nx = (sts.area_zero || !sts.box_ok) ? ST_DONE : ST_WALK;
				end
			end
			ST_WALK: begin
				if (sts.walk_last) state_nx = ST_DONE;
			end
			ST_RD: begin
				state_nx = ST_DONE;
			end
			ST_CLR: begin
				if (sts.clr_last) state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_BOOT: begin
				cmd.clr_en = 1'b1;
			end
			ST_IDLE: begin
				cmd.load = in_valid;
			end
			ST_SETUP: begin
				cmd.mul_en  = (step_q < STEPW'(MUL_STEPS));
				cmd.mul_sel = step_q[2:0];
			end
			ST_WALK: begin
				cmd.walk_en = 1'b1;
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
			end
			ST_CLR: begin
				cmd.clr_en = 1'b1;
			end
			ST_DONE: begin
				cmd.res_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state, setup step and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BOOT;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			step_q  <= (state_q == ST_SETUP) ? step_q + 1'b1 : '0;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// an accepted item always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("accepted item did not start work");

	// a result never overwrites one that is still held by the receiver
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> out_free)
		else $error("result register loaded while stalled");

	// the walk runs only for a draw with a nondegenerate triangle whose box corner is on the grid
	a_walk_draw_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_en |-> (sts.op == OP_DRAW && !sts.area_zero && sts.box_ok))
		else $error("pixel walk for a non-drawing item");

	// the bitmap is never written while a read is issued
	a_rd_clr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !(cmd.clr_en || cmd.walk_en))
		else $error("bitmap read overlaps a write phase");

endmodule

>>> sv/triangle_coverage_rasterizer_core.sv
// ----------------------------------------------------------------------------
// triangle_coverage_rasterizer_core: triangle coverage bitmap rasterizer
// Usage:
//   Input channel (in_valid/in_stall) carries one item per transfer: draw a
//   triangle, read one pixel, or clear the bitmap. Output channel
//   (out_valid/out_stall) returns exactly one result per item, in order.
//   Only one item is in work at a time; in_stall is low only when idle.
//   Work done for each item before out_valid:
//     draw  : setup multiplies, then the single-pixel edge-function walk over
//             the clipped bounding box (up to GRID*GRID pixels); a degenerate
//             or fully off-grid triangle skips the walk.
//     read  : one registered bitmap RAM read.
//     clear : the whole bitmap, one bitmap entry written per cycle.
//     unused operation code: no bitmap work.
//   After reset all GRID*GRID bitmap entries (65536 at the default) are swept
//   to zero before the first item is taken. A held result stays on the output
//   while out_stall is high; the next item can be accepted meanwhile and its
//   result waits until the held one has transferred.
// ----------------------------------------------------------------------------
module triangle_coverage_rasterizer_core import trcr_pkg::*; #(
	parameter int GRID = GRID_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [1:0]      operation,
	input  logic [CW-1:0]   vert0_x,
	input  logic [CW-1:0]   vert0_y,
	input  logic [CW-1:0]   vert1_x,
	input  logic [CW-1:0]   vert1_y,
	input  logic [CW-1:0]   vert2_x,
	input  logic [CW-1:0]   vert2_y,
	input  logic [7:0]      pixel_col,
	input  logic [7:0]      pixel_row,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            painted,
	output logic [15:0]     blue_half,
	output logic [CNTW-1:0] covered_count
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// sequencer
	trcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// edge-function datapath and bitmap
	trcr_dp #(
		.GRID (GRID)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.vert0_x       (vert0_x),
		.vert0_y       (vert0_y),
		.vert1_x       (vert1_x),
		.vert1_y       (vert1_y),
		.vert2_x       (vert2_x),
		.vert2_y       (vert2_y),
		.pixel_col     (pixel_col),
		.pixel_row     (pixel_row),
		.painted       (painted),
		.blue_half     (blue_half),
		.covered_count (covered_count)
	);

endmodule
